@@ rtl/slfr_pkg.sv @@
// ----------------------------------------------------------------------------
// slfr_pkg
// Types, constants and the CRC-8 step shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package slfr_pkg;

    localparam logic [7:0]  SYNC_FIRST       = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND      = 8'h55;
    localparam logic [7:0]  CRC_POLY         = 8'h07;
    localparam logic [7:0]  CRC_TOPBIT       = 8'h80;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic        crc_ok;
        logic [15:0] payload_length;
        logic [15:0] byte_index;
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic        out_kind;
    } slfr_result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOPBIT) != 8'd0)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

@@ rtl/slfr_parser.sv @@
// ----------------------------------------------------------------------------
// slfr_parser
// Front end: sync hunt, header capture, payload tracking and check byte test.
// ----------------------------------------------------------------------------
module slfr_parser
    import slfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    input  logic [7:0]   byte_in,
    input  logic [15:0]  max_length,
    output logic         push,
    output slfr_result_t result
);

    typedef enum logic [2:0] {
        PH_SYNC0   = 3'd0,
        PH_SYNC1   = 3'd1,
        PH_CMD     = 3'd2,
        PH_LENLO   = 3'd3,
        PH_LENHI   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  hdr_crc_reg, hdr_crc_next;
    logic [7:0]  pay_crc_reg, pay_crc_next;
    logic [15:0] new_length;
    logic [16:0] count_inc;

    assign new_length = {byte_in, length_low_reg};
    assign count_inc  = {1'b0, count_reg} + 17'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        command_next    = command_reg;
        length_low_next = length_low_reg;
        length_next     = length_reg;
        count_next      = count_reg;
        hdr_crc_next    = hdr_crc_reg;
        pay_crc_next    = pay_crc_reg;
        push            = 1'b0;
        result          = '0;
        result.command        = command_reg;
        result.payload_length = length_reg;
        if (byte_valid)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    phase_next = (byte_in == SYNC_SECOND) ? PH_CMD : PH_SYNC0;
                end
                PH_CMD:
                begin
                    command_next = byte_in;
                    hdr_crc_next = crc8_update(8'd0, byte_in);
                    phase_next   = PH_LENLO;
                end
                PH_LENLO:
                begin
                    length_low_next = byte_in;
                    hdr_crc_next    = crc8_update(hdr_crc_reg, byte_in);
                    phase_next      = PH_LENHI;
                end
                PH_LENHI:
                begin
                    hdr_crc_next = crc8_update(hdr_crc_reg, byte_in);
                    length_next  = new_length;
                    count_next   = 16'd0;
                    pay_crc_next = 8'd0;
                    if (new_length == 16'd0)
                        phase_next = PH_CHECK;
                    else if (new_length > max_length)
                        phase_next = PH_SYNC0;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    pay_crc_next = crc8_update(pay_crc_reg, byte_in);
                    count_next   = count_inc[15:0];
                    if (count_inc >= {1'b0, length_reg})
                        phase_next = PH_CHECK;
                    push              = 1'b1;
                    result.out_kind   = KIND_PAYLOAD;
                    result.data_byte  = byte_in;
                    result.byte_index = count_reg;
                end
                PH_CHECK:
                begin
                    phase_next      = PH_SYNC0;
                    push            = 1'b1;
                    result.out_kind = KIND_FRAME_END;
                    result.crc_ok   = (byte_in == (hdr_crc_reg ^ pay_crc_reg));
                end
                default:
                begin
                    phase_next = (byte_in == SYNC_FIRST) ? PH_SYNC1 : PH_SYNC0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC0;
            command_reg    <= 8'd0;
            length_low_reg <= 8'd0;
            length_reg     <= 16'd0;
            count_reg      <= 16'd0;
            hdr_crc_reg    <= 8'd0;
            pay_crc_reg    <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            command_reg    <= command_next;
            length_low_reg <= length_low_next;
            length_reg     <= length_next;
            count_reg      <= count_next;
            hdr_crc_reg    <= hdr_crc_next;
            pay_crc_reg    <= pay_crc_next;
        end
    end

endmodule

@@ rtl/slfr_queue.sv @@
// ----------------------------------------------------------------------------
// slfr_queue
// Short result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module slfr_queue
    import slfr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  slfr_result_t push_data,
    input  logic         pop,
    output logic         not_full,
    output logic         not_empty,
    output slfr_result_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    slfr_result_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ rtl/sync_length_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Sync/length framed packet receiver with CRC-8 check of header and payload.
//
//   channel   dir  handshake                 contents
//   s_axis    in   s_tvalid / s_tready       tdata: rx_byte
//   m_axis    out  m_tvalid / m_tready       tuser: out_kind; tdata: result
//   cfg       in   cfg_valid / cfg_ready     max_length
//
// One byte per cycle while s_tready is high; the parser updates its state in
// the accept cycle, and any result it pushes goes into the result queue and reaches m_axis behind earlier entries.
// s_tready drops only when the result queue (QUEUE_DEPTH entries) is full.
// Reset: phase back to sync hunt, queue empty, max_length = 256.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver
    import slfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] command, [15:8] data_byte,
                                              // [31:16] byte_index,
                                              // [47:32] payload_length,
                                              // [48] crc_ok, [55:49] zero
    output logic                   m_tuser,   // [0] out_kind
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);

    logic [15:0]  max_length_reg;
    logic         in_xfer;
    logic         push;
    slfr_result_t result;
    slfr_result_t head;
    logic         not_full;
    logic         not_empty;

    assign cfg_ready = 1'b1;
    assign s_tready  = not_full;
    assign in_xfer   = s_tvalid && not_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RESET;
        else if (cfg_valid)
            max_length_reg <= cfg_data;
    end

    slfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_xfer),
        .byte_in    (s_tdata),
        .max_length (max_length_reg),
        .push       (push),
        .result     (result)
    );

    slfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (m_tready),
        .not_full  (not_full),
        .not_empty (not_empty),
        .head      (head)
    );

    assign m_tvalid = not_empty;
    assign m_tuser  = head.out_kind;
    assign m_tdata  = {7'd0, head.crc_ok, head.payload_length, head.byte_index,
                       head.data_byte, head.command};

endmodule

@@ rtl/slfr_checker.sv @@
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks on the frame receiver result channel.
// ----------------------------------------------------------------------------
module slfr_checker
    import slfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_FRAME_END) |->
            (m_tdata[15:8] == 8'd0) && (m_tdata[31:16] == 16'd0))
        else $error("frame end carries data or index");

    a_payload_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_PAYLOAD) |-> !m_tdata[48])
        else $error("payload transfer with crc_ok set");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_PAYLOAD) |-> (m_tdata[31:16] < m_tdata[47:32]))
        else $error("payload index beyond declared length");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:49] == '0))
        else $error("tdata padding not zero");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
